### rtl/dsa_pkg.sv
// Shared types and codes for the descriptor slot allocator.
// No dependencies; dsa_core and descriptor_slot_allocator import this package.
package dsa_pkg;

  localparam int CNT_W    = 13;
  localparam int BASE_W   = 20;
  localparam int HANDLE_W = 48;
  localparam int INDEX_W  = 32;
  localparam int STAT_W   = 3;
  localparam int REG_W    = 2;
  localparam int CFG_D_W  = 20;

  typedef logic [1:0]        cmd_t;
  typedef logic [STAT_W-1:0] status_t;
  typedef logic [REG_W-1:0]  reg_idx_t;

  localparam cmd_t CMD_ALLOC = 2'd0;
  localparam cmd_t CMD_FREE  = 2'd1;
  localparam cmd_t CMD_QUERY = 2'd2;

  localparam status_t ST_OK          = 3'd0;
  localparam status_t ST_NOT_READY   = 3'd1;
  localparam status_t ST_NULL_HANDLE = 3'd2;
  localparam status_t ST_FULL        = 3'd3;
  localparam status_t ST_SENTINEL    = 3'd4;
  localparam status_t ST_RANGE       = 3'd5;
  localparam status_t ST_OVER_FREE   = 3'd6;

  localparam reg_idx_t REG_TABLE_READY = 2'd0;
  localparam reg_idx_t REG_BASE_INDEX  = 2'd1;
  localparam reg_idx_t REG_CAPACITY    = 2'd2;

  typedef struct packed {
    logic              table_ready;
    logic [BASE_W-1:0] base_index;
    logic [CNT_W-1:0]  capacity;
  } cfg_t;

  typedef struct packed {
    cmd_t               cmd;
    logic               handle_nz;
    logic [INDEX_W-1:0] release_index;
  } req_t;

  typedef struct packed {
    logic [INDEX_W-1:0] result_index;
    status_t            status;
    logic [CNT_W-1:0]   used_count;
  } rsp_t;

endpackage

### rtl/dsa_if.sv
// Channel interfaces of the descriptor slot allocator: request, result, config write.
// No dependencies.
interface dsa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [47:0] source_handle;
  logic [31:0] release_index;
  modport source (output valid, cmd, source_handle, release_index, input ready);
  modport sink   (input valid, cmd, source_handle, release_index, output ready);
endinterface

interface dsa_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_index;
  logic [2:0]  status;
  logic [12:0] used_count;
  modport source (output valid, result_index, status, used_count, input ready);
  modport sink   (input valid, result_index, status, used_count, output ready);
endinterface

interface dsa_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [19:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/dsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dsa_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/dsa_core.sv
// Allocation logic: counters, top-of-stack register and the free stack memory.
// Depends on dsa_pkg and dsa_ram.
module dsa_core
  import dsa_pkg::*;
#(
  parameter int MAX_SLOTS = 4096
) (
  input  logic clk,
  input  logic rst_n,
  input  logic fire,
  input  req_t req,
  input  cfg_t cfg,
  output rsp_t rsp
);

  localparam int AW      = MAX_SLOTS > 1 ? $clog2(MAX_SLOTS) : 1;
  localparam int WIN_MAX = MAX_SLOTS < 8191 ? MAX_SLOTS : 8191;
  localparam logic [CNT_W-1:0] WIN_LIM = CNT_W'(WIN_MAX);

  logic [CNT_W-1:0]   fc_r, fc_nxt;
  logic [CNT_W-1:0]   no_r, no_nxt;
  logic [AW-1:0]      tos_r, tos_nxt;
  logic [AW-1:0]      rd_data;
  logic [AW-1:0]      off;
  logic [AW-1:0]      wdata;
  logic               we;
  logic [CNT_W-1:0]   window;
  logic [BASE_W:0]    hi;
  logic [INDEX_W-1:0] rel_off;

  assign window  = (cfg.capacity > WIN_LIM) ? WIN_LIM : cfg.capacity;
  assign hi      = {1'b0, cfg.base_index} + (BASE_W + 1)'(window);
  assign rel_off = req.release_index - INDEX_W'(cfg.base_index);
  assign wdata   = AW'(rel_off);

  always_comb begin
    fc_nxt           = fc_r;
    no_nxt           = no_r;
    tos_nxt          = tos_r;
    we               = 1'b0;
    off              = tos_r;
    rsp.result_index = '1;
    rsp.status       = ST_OK;
    if (fire) begin
      if (req.cmd == CMD_ALLOC) begin
        if (!cfg.table_ready) begin
          rsp.status = ST_NOT_READY;
        end else if (!req.handle_nz) begin
          rsp.status = ST_NULL_HANDLE;
        end else if (fc_r != '0) begin
          off              = tos_r;
          fc_nxt           = fc_r - CNT_W'(1);
          tos_nxt          = rd_data;
          rsp.result_index = INDEX_W'(cfg.base_index) + INDEX_W'(off);
        end else if (no_r < window) begin
          off              = AW'(no_r);
          no_nxt           = no_r + CNT_W'(1);
          rsp.result_index = INDEX_W'(cfg.base_index) + INDEX_W'(off);
        end else begin
          rsp.status = ST_FULL;
        end
      end else if (req.cmd == CMD_FREE) begin
        if (req.release_index == '1) begin
          rsp.status = ST_SENTINEL;
        end else if (req.release_index < INDEX_W'(cfg.base_index) ||
                     req.release_index >= INDEX_W'(hi)) begin
          rsp.status = ST_RANGE;
        end else if (fc_r >= no_r) begin
          rsp.status = ST_OVER_FREE;
        end else begin
          we      = 1'b1;
          tos_nxt = wdata;
          fc_nxt  = fc_r + CNT_W'(1);
        end
      end
    end
    rsp.used_count = no_nxt - fc_nxt;
  end

  // read port always tracks the entry just below the next top of stack
  dsa_ram #(
    .WIDTH (AW),
    .DEPTH (MAX_SLOTS)
  ) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(fc_r)),
    .wdata (wdata),
    .raddr (AW'(fc_nxt - CNT_W'(2))),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r <= '0;
      no_r <= '0;
    end else begin
      fc_r <= fc_nxt;
      no_r <= no_nxt;
    end
    tos_r <= tos_nxt;
  end

endmodule

### rtl/descriptor_slot_allocator.sv
// Descriptor slot allocator: hands out slot indices base_index + offset from a
// window of capacity slots, reusing freed offsets last-in first-out before bumping
// a fresh-offset counter. One item is accepted every cycle unless the result output
// stalls; each result passes through the input register, one pass of allocation
// logic and the result register. The next stack entry is prefetched from the free
// stack memory into a top-of-stack register, so back-to-back pops need no stall. The
// free stack memory has no clearing pass: the block is ready right after reset.
// Depends on dsa_pkg, the dsa_*_if interfaces and dsa_core.
module descriptor_slot_allocator
  import dsa_pkg::*;
#(
  parameter int MAX_SLOTS = 4096
) (
  input logic           clk,
  input logic           rst_n,
  dsa_in_if.sink        in_req,
  dsa_out_if.source     out_rsp,
  dsa_cfg_if.sink       cfg_wr
);

  cfg_t cfg_r;
  logic v1_r;
  req_t req_r;
  logic out_valid_r;
  rsp_t rsp_r;
  rsp_t rsp_nxt;
  logic adv;
  logic fire;

  assign adv          = !out_valid_r || out_rsp.ready;
  assign fire         = v1_r && adv;
  assign in_req.ready = !v1_r || adv;
  assign cfg_wr.ready = 1'b1;

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.result_index = rsp_r.result_index;
  assign out_rsp.status       = rsp_r.status;
  assign out_rsp.used_count   = rsp_r.used_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        REG_TABLE_READY: cfg_r.table_ready <= cfg_wr.data[0];
        REG_BASE_INDEX:  cfg_r.base_index  <= cfg_wr.data[BASE_W-1:0];
        REG_CAPACITY:    cfg_r.capacity    <= cfg_wr.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_req.ready) begin
        v1_r <= in_req.valid;
      end
      if (adv) begin
        out_valid_r <= fire;
      end
    end
    if (in_req.valid && in_req.ready) begin
      req_r.cmd           <= in_req.cmd;
      req_r.handle_nz     <= (in_req.source_handle != '0);
      req_r.release_index <= in_req.release_index;
    end
    if (fire) begin
      rsp_r <= rsp_nxt;
    end
  end

  dsa_core #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .req   (req_r),
    .cfg   (cfg_r),
    .rsp   (rsp_nxt)
  );

`ifndef NO_ASSERTIONS
  a_fire_shows: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("accepted item did not reach the result register");

  a_fail_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && req_r.cmd == CMD_ALLOC && rsp_nxt.status != ST_OK) |->
      rsp_nxt.result_index == '1)
    else $error("failed allocation returned an index");

  a_ok_alloc_index: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && req_r.cmd == CMD_ALLOC && rsp_nxt.status == ST_OK) |->
      rsp_nxt.result_index != '1)
    else $error("successful allocation returned all ones");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> {19'd0, rsp_r.used_count} <= 32'(MAX_SLOTS))
    else $error("used count beyond slot limit");
`endif

endmodule
